@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk_i and held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mbfr_pkg.sv @@
// ----------------------------------------------------------------------------
// mbfr_pkg
// widths, opcodes and constants of the msb-first bit-field reader
// ----------------------------------------------------------------------------
`default_nettype none

package mbfr_pkg;

  // buffer geometry
  localparam int unsigned BufBytes = 4096;
  localparam int unsigned AddrW    = $clog2(BufBytes);
  localparam int unsigned PosW     = AddrW + 1;

  // field geometry
  localparam int unsigned MaxFieldBits = 32;
  localparam int unsigned FieldW       = 32;
  localparam int unsigned IdxW         = $clog2(FieldW);
  localparam int unsigned CountW       = 6;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned BitsW        = 4;

  // stream data widths
  localparam int unsigned InTdataW  = 32;
  localparam int unsigned OutTdataW = 48;

  // operation codes
  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_START  = 3'd1,
    OP_READ_U = 3'd2,
    OP_READ_S = 3'd3,
    OP_ALIGN  = 3'd4
  } op_e;

endpackage

`default_nettype wire

@@ rtl/msb_first_bit_field_reader.sv @@
// ----------------------------------------------------------------------------
// msb_first_bit_field_reader
// write, start, align and zero-bit reads load their item into the output register on accept
// a read of n bits over B bytes (1 to 5) runs fetch, one byte at a time, then fin, which loads the output
// throughput: one byte per cycle from the single buffer read port; no new item is taken until a read is done
// reset: cursor at byte 0, bit 7; buffer contents are not cleared, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module msb_first_bit_field_reader
  import mbfr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // op[2:0], byte_address[14:3], byte_value[22:15], bit_count[28:23], zero pad
  input  wire logic [InTdataW-1:0]  s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // field_value[31:0], byte_position[44:32], overrun[45], zero pad
  output logic      [OutTdataW-1:0] m_axis_tdata_o
);

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_FIN   = 3'b100
  } state_e;

  localparam logic [PosW-1:0]   BufPos   = PosW'(BufBytes);
  localparam logic [CountW-1:0] MaxCount = CountW'(MaxFieldBits);
  localparam logic [BitsW-1:0]  FullByte = BitsW'(ByteW);

  // item fields
  op_e               in_op;
  logic [AddrW-1:0]  in_addr;
  logic [ByteW-1:0]  in_byte;
  logic [CountW-1:0] in_count;
  logic [CountW-1:0] count_sat;

  assign in_op     = op_e'(s_axis_tdata_i[2:0]);
  assign in_addr   = s_axis_tdata_i[14:3];
  assign in_byte   = s_axis_tdata_i[22:15];
  assign in_count  = s_axis_tdata_i[28:23];
  assign count_sat = (in_count > MaxCount) ? MaxCount : in_count;

  // state
  state_e            state_q, state_d;
  logic [PosW-1:0]   cursor_q, cursor_d;
  logic [BitsW-1:0]  bits_q, bits_d;
  logic [CountW-1:0] remain_q, remain_d;
  logic [CountW-1:0] count_q, count_d;
  logic              signed_q, signed_d;
  logic              ovr_q, ovr_d;
  logic [FieldW-1:0] acc_q, acc_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [FieldW-1:0] out_value_q, out_value_d;
  logic [PosW-1:0]   out_pos_q, out_pos_d;
  logic              out_ovr_q, out_ovr_d;
  logic              out_load;

  logic out_free;
  logic accept;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // byte buffer, read address follows the next cursor
  logic [ByteW-1:0] rdata;
  logic             ram_we;

  assign ram_we = accept && (in_op == OP_WRITE);

  mbfr_byte_ram #(
    .ADDR_W (AddrW),
    .DATA_W (ByteW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_addr),
    .wdata_i (in_byte),
    .raddr_i (cursor_d[AddrW-1:0]),
    .rdata_o (rdata)
  );

  // cursor step, held at the buffer end
  logic [PosW-1:0] cursor_step;
  assign cursor_step = (cursor_q < BufPos) ? cursor_q + PosW'(1) : cursor_q;

  // extraction of up to one byte per cycle
  logic             byte_ok;
  logic [ByteW-1:0] byte_data;
  logic [BitsW-1:0] take;
  logic [ByteW-1:0] shifted;
  logic [ByteW:0]   take_mask;
  logic [ByteW-1:0] taken;
  logic [FieldW-1:0] acc_next;
  logic [CountW-1:0] remain_next;
  logic [BitsW-1:0]  bits_next;

  always_comb begin
    byte_ok     = cursor_q < BufPos;
    byte_data   = byte_ok ? rdata : '0;
    take        = (remain_q < CountW'(bits_q)) ? remain_q[BitsW-1:0] : bits_q;
    shifted     = byte_data >> (bits_q - take);
    take_mask   = ((ByteW+1)'(1) << take) - (ByteW+1)'(1);
    taken       = shifted & take_mask[ByteW-1:0];
    acc_next    = (acc_q << take) | FieldW'(taken);
    remain_next = remain_q - CountW'(take);
    bits_next   = bits_q - take;
  end

  // sign extension of the finished field
  logic [IdxW-1:0]   sign_idx;
  logic [FieldW-1:0] sign_ext;
  logic [FieldW-1:0] final_value;

  always_comb begin
    sign_idx    = IdxW'(count_q - CountW'(1));
    sign_ext    = {FieldW{1'b1}} << sign_idx;
    final_value = (signed_q && acc_q[sign_idx]) ? (acc_q | sign_ext) : acc_q;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    bits_d      = bits_q;
    remain_d    = remain_q;
    count_d     = count_q;
    signed_d    = signed_q;
    ovr_d       = ovr_q;
    acc_d       = acc_q;
    out_load    = 1'b0;
    out_value_d = '0;
    out_pos_d   = cursor_q;
    out_ovr_d   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          unique case (in_op) inside
            OP_WRITE: begin
            end
            OP_START: begin
              cursor_d = PosW'(in_addr);
              bits_d   = FullByte;
            end
            OP_READ_U, OP_READ_S: begin
              if (count_sat != '0) begin
                out_load = 1'b0;
                state_d  = ST_FETCH;
                remain_d = count_sat;
                count_d  = count_sat;
                signed_d = (in_op == OP_READ_S);
                ovr_d    = 1'b0;
                acc_d    = '0;
                // lazy step onto the next byte
                if (bits_q == '0) begin
                  cursor_d = cursor_step;
                  bits_d   = FullByte;
                end
              end
            end
            OP_ALIGN: begin
              if (bits_q != FullByte) begin
                cursor_d = cursor_step;
              end
              bits_d = FullByte;
            end
            default: begin
            end
          endcase
          out_pos_d = cursor_d;
        end
      end
      ST_FETCH: begin
        acc_d    = acc_next;
        remain_d = remain_next;
        ovr_d    = ovr_q | !byte_ok;
        if (remain_next == '0) begin
          bits_d  = bits_next;
          state_d = ST_FIN;
        end else begin
          // current byte used up, move on and fetch the next one
          cursor_d = cursor_step;
          bits_d   = FullByte;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_value_d = final_value;
          out_pos_d   = cursor_q;
          out_ovr_d   = ovr_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_q    <= '0;
      bits_q      <= FullByte;
      remain_q    <= '0;
      count_q     <= '0;
      signed_q    <= 1'b0;
      ovr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      bits_q      <= bits_d;
      remain_q    <= remain_d;
      count_q     <= count_d;
      signed_q    <= signed_d;
      ovr_q       <= ovr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (out_load) begin
      out_value_q <= out_value_d;
      out_pos_q   <= out_pos_d;
      out_ovr_q   <= out_ovr_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_ovr_q, out_pos_q, out_value_q};

  // read item that starts a fetch
  logic rd_start;
  assign rd_start = accept && (in_op == OP_READ_U || in_op == OP_READ_S) && (count_sat != '0);

  // checks
  `ASSERT_ALWAYS(a_cursor_in_range, cursor_q <= BufPos, "cursor past buffer end")
  `ASSERT_ALWAYS(a_bits_in_range, bits_q <= FullByte, "bit position out of range")
  `ASSERT_ALWAYS(a_fetch_has_work, (state_q != ST_FETCH) || (remain_q != '0),
                 "fetch with no bits left")
  `ASSERT_NEXT(a_read_starts, rd_start, state_q == ST_FETCH && bits_q != '0,
               "read did not start a fetch")

endmodule

`default_nettype wire

@@ rtl/mbfr_byte_ram.sv @@
// ----------------------------------------------------------------------------
// mbfr_byte_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mbfr_byte_ram #(
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
